[sv/gcdf_pkg.sv]
`default_nettype none

package gcdf_pkg;

	// Field widths
	localparam int OP_W      = 2;
	localparam int ROW_W     = 6;
	localparam int COL_W     = 6;
	localparam int VAL_W     = 16;
	localparam int LVL_W     = 13;
	localparam int DIM_W     = 7;
	localparam int CFG_IDX_W = 2;
	localparam int TDATA_W   = 32;

	// Operation codes carried on s_tuser
	localparam logic [OP_W-1:0] OP_WRITE = 2'd0;
	localparam logic [OP_W-1:0] OP_BUILD = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEED = 2'd2;

	// Cell store command
	typedef struct packed {
		logic rd;
		logic wr;
	} cmd_t;

	// Build area and seed handed to the sweep sequencer
	typedef struct packed {
		logic [DIM_W-1:0] rows;
		logic [DIM_W-1:0] cols;
		logic [VAL_W-1:0] seed;
	} sweep_cfg_t;

endpackage

`default_nettype wire

[sv/gcdf_cell_store.sv]
`default_nettype none

module gcdf_cell_store #(
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic                      clk,
	input  wire gcdf_pkg::cmd_t            cmd,
	input  wire logic [AW-1:0]             addr,
	input  wire logic [gcdf_pkg::VAL_W-1:0] wdata,
	output logic      [gcdf_pkg::VAL_W-1:0] rdata
);
	import gcdf_pkg::*;

	logic [VAL_W-1:0] mem [DEPTH];
	logic [VAL_W-1:0] rdata_q;

	// Single port: write or registered read at one address per cycle
	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[addr] <= wdata;
		end
		if (cmd.rd) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

[sv/gcdf_sweep.sv]
`default_nettype none

module gcdf_sweep #(
	parameter int MAX_COLS = 64,
	parameter int AW       = 12
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire gcdf_pkg::sweep_cfg_t       cfg,
	input  wire logic [gcdf_pkg::VAL_W-1:0] rdata,
	output logic                            busy,
	output logic                            done,
	output logic      [gcdf_pkg::LVL_W-1:0] final_level,
	output gcdf_pkg::cmd_t                  cmd,
	output logic      [AW-1:0]              addr,
	output logic      [gcdf_pkg::VAL_W-1:0] wdata
);
	import gcdf_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CRD  = 3'd1;
	localparam logic [2:0] S_CCHK = 3'd2;
	localparam logic [2:0] S_NRD  = 3'd3;
	localparam logic [2:0] S_NWR  = 3'd4;
	localparam logic [2:0] S_PEND = 3'd5;

	logic [2:0]       state_q;
	logic [DIM_W-1:0] r_q;
	logic [DIM_W-1:0] c_q;
	logic [1:0]       dri_q;
	logic [1:0]       dci_q;
	logic [VAL_W-1:0] match_q;
	logic [VAL_W-1:0] level_q;
	logic             filled_q;

	logic [DIM_W:0]   nrr;
	logic [DIM_W:0]   ncc;
	logic [DIM_W-1:0] rr;
	logic [DIM_W-1:0] cc;
	logic             nb_in;
	logic             area_ok;
	logic             last_col;
	logic             last_row;
	logic [DIM_W-1:0] a_row;
	logic [DIM_W-1:0] a_col;

	// Neighbour position, offset by one so nothing goes negative
	assign nrr   = {1'b0, r_q} + {{(DIM_W-1){1'b0}}, dri_q};
	assign ncc   = {1'b0, c_q} + {{(DIM_W-1){1'b0}}, dci_q};
	assign rr    = DIM_W'(nrr - 1'b1);
	assign cc    = DIM_W'(ncc - 1'b1);
	assign nb_in = (nrr != '0) && (nrr <= {1'b0, cfg.rows}) &&
		(ncc != '0) && (ncc <= {1'b0, cfg.cols});

	assign area_ok  = (cfg.rows != '0) && (cfg.cols != '0);
	assign last_col = ({1'b0, c_q} + 1'b1) >= {1'b0, cfg.cols};
	assign last_row = ({1'b0, r_q} + 1'b1) >= {1'b0, cfg.rows};

	// Shared address unit: center cell on the center read, neighbour otherwise
	assign a_row = (state_q == S_CRD) ? r_q : rr;
	assign a_col = (state_q == S_CRD) ? c_q : cc;
	assign addr  = AW'(int'(a_row) * MAX_COLS + int'(a_col));
	assign wdata = level_q;

	// Store commands
	always_comb begin
		cmd = '0;
		case (state_q)
			S_CRD: begin
				cmd.rd = area_ok;
			end
			S_NRD: begin
				cmd.rd = nb_in;
			end
			S_NWR: begin
				cmd.wr = (rdata == '0);
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Sequencer: raster walk, nine neighbours per matching cell, pass loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			r_q      <= '0;
			c_q      <= '0;
			dri_q    <= '0;
			dci_q    <= '0;
			match_q  <= '0;
			level_q  <= '0;
			filled_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						r_q      <= '0;
						c_q      <= '0;
						dri_q    <= '0;
						dci_q    <= '0;
						match_q  <= cfg.seed;
						level_q  <= VAL_W'(1);
						filled_q <= 1'b0;
						state_q  <= S_CRD;
					end
				end
				S_CRD: begin
					state_q <= area_ok ? S_CCHK : S_PEND;
				end
				S_CCHK, S_NRD, S_NWR: begin
					if (state_q == S_NWR && rdata == '0) begin
						filled_q <= 1'b1;
					end
					if (state_q == S_CCHK && rdata == match_q) begin
						dri_q   <= '0;
						dci_q   <= '0;
						state_q <= S_NRD;
					end else if (state_q == S_NRD && nb_in) begin
						state_q <= S_NWR;
					end else if (state_q != S_CCHK && dci_q != 2'd2) begin
						dci_q   <= dci_q + 1'b1;
						state_q <= S_NRD;
					end else if (state_q != S_CCHK && dri_q != 2'd2) begin
						dci_q   <= '0;
						dri_q   <= dri_q + 1'b1;
						state_q <= S_NRD;
					end else begin
						// Advance to the next cell of the raster
						dri_q <= '0;
						dci_q <= '0;
						if (!last_col) begin
							c_q     <= c_q + 1'b1;
							state_q <= S_CRD;
						end else begin
							c_q <= '0;
							if (!last_row) begin
								r_q     <= r_q + 1'b1;
								state_q <= S_CRD;
							end else begin
								r_q     <= '0;
								state_q <= S_PEND;
							end
						end
					end
				end
				S_PEND: begin
					if (filled_q) begin
						match_q  <= level_q;
						level_q  <= level_q + 1'b1;
						filled_q <= 1'b0;
						r_q      <= '0;
						c_q      <= '0;
						state_q  <= S_CRD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q != S_IDLE);
	assign done        = (state_q == S_PEND) && !filled_q;
	assign final_level = level_q[LVL_W-1:0];

	// A neighbour write lands on the address read just before
	a_wr_after_rd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.wr |-> ($past(cmd.rd) && addr == $past(addr)))
		else $error("neighbour write without matching read");

	// The fill flag rises only after a cell was written
	a_fill_flag: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(filled_q) |-> $past(cmd.wr))
		else $error("fill flag set without a write");

	// Level never drops within a build
	a_level_mono: assert property (@(posedge clk) disable iff (!arst_n)
		(busy && $past(busy)) |-> (level_q >= $past(level_q)))
		else $error("level decreased during build");

endmodule

`default_nettype wire

[sv/grid_chessboard_distance_fill_unit.sv]
// Chessboard distance fill over a grid of 16-bit cells held in one single-port
// memory of MAX_ROWS x MAX_COLS entries (address row*MAX_COLS+col). The memory
// is not cleared: a cell reads as garbage until written, so load every cell the
// build area touches before a build. s_tuser selects the operation: write
// returns nothing; read returns the cell through the store read register and
// the output register; build returns the final level once done. A build walks
// the used area once per pass: each cell takes a center read state and a check
// state, and a cell equal to the match value (the seed, then the level last
// written) takes a read state per neighbour and a write state per in-bounds
// neighbour, plus a pending state at the end of each pass. Passes continue until
// one fills nothing. The block takes no item while a build or read is in flight.
`default_nettype none

module grid_chessboard_distance_fill_unit #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// s_tdata: row [5:0], col [11:6], cell_in [27:12], zero [31:28]
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [gcdf_pkg::TDATA_W-1:0]      s_tdata,
	// s_tuser: operation [1:0]
	input  wire logic [gcdf_pkg::OP_W-1:0]         s_tuser,
	// m_tdata: cell_out [15:0], final_level [28:16], zero [31:29]
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [gcdf_pkg::TDATA_W-1:0]      m_tdata,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [gcdf_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [gcdf_pkg::VAL_W-1:0]        cfg_data
);
	import gcdf_pkg::*;

	localparam int DEPTH = MAX_ROWS * MAX_COLS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [DIM_W-1:0] rows_q;
	logic [DIM_W-1:0] cols_q;
	logic [VAL_W-1:0] seed_q;

	logic [ROW_W-1:0] in_row;
	logic [COL_W-1:0] in_col;
	logic [VAL_W-1:0] in_cell;
	logic             acc;
	logic             ld_inside;
	logic [AW-1:0]    ld_addr;

	sweep_cfg_t       scfg;
	logic             eng_busy;
	logic             eng_done;
	logic [LVL_W-1:0] eng_level;
	cmd_t             eng_cmd;
	logic [AW-1:0]    eng_addr;
	logic [VAL_W-1:0] eng_wdata;

	cmd_t             mem_cmd;
	logic [AW-1:0]    mem_addr;
	logic [VAL_W-1:0] mem_wdata;
	logic [VAL_W-1:0] mem_rdata;

	logic             rd_pend_q;
	logic             rd_inside_q;
	logic             out_valid_q;
	logic [VAL_W-1:0] out_cell_q;
	logic [LVL_W-1:0] out_level_q;

	// Configuration registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= DIM_W'(64);
			cols_q <= DIM_W'(64);
			seed_q <= VAL_W'(2);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ROWS: rows_q <= cfg_data[DIM_W-1:0];
				REG_COLS: cols_q <= cfg_data[DIM_W-1:0];
				REG_SEED: seed_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Clamp the build area to the store
	assign scfg.rows = (int'(rows_q) > MAX_ROWS) ? DIM_W'(MAX_ROWS) : rows_q;
	assign scfg.cols = (int'(cols_q) > MAX_COLS) ? DIM_W'(MAX_COLS) : cols_q;
	assign scfg.seed = seed_q;

	// Input unpack and loader address
	assign in_row    = s_tdata[ROW_W-1:0];
	assign in_col    = s_tdata[ROW_W+COL_W-1:ROW_W];
	assign in_cell   = s_tdata[ROW_W+COL_W+VAL_W-1:ROW_W+COL_W];
	assign ld_inside = (int'(in_row) < MAX_ROWS) && (int'(in_col) < MAX_COLS);
	assign ld_addr   = AW'(int'(in_row) * MAX_COLS + int'(in_col));

	assign s_tready = !eng_busy && !rd_pend_q && (!out_valid_q || m_tready);
	assign acc      = s_tvalid && s_tready;

	gcdf_sweep #(
		.MAX_COLS (MAX_COLS),
		.AW       (AW)
	) u_sweep (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (acc && s_tuser == OP_BUILD),
		.cfg         (scfg),
		.rdata       (mem_rdata),
		.busy        (eng_busy),
		.done        (eng_done),
		.final_level (eng_level),
		.cmd         (eng_cmd),
		.addr        (eng_addr),
		.wdata       (eng_wdata)
	);

	// Memory port: sequencer while building, loader otherwise
	always_comb begin
		if (eng_busy) begin
			mem_cmd   = eng_cmd;
			mem_addr  = eng_addr;
			mem_wdata = eng_wdata;
		end else begin
			mem_cmd.wr = acc && (s_tuser == OP_WRITE) && ld_inside;
			mem_cmd.rd = acc && (s_tuser == OP_READ) && ld_inside;
			mem_addr   = ld_addr;
			mem_wdata  = in_cell;
		end
	end

	gcdf_cell_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.cmd   (mem_cmd),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

	// Track a read until its data returns
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_pend_q <= 1'b0;
		end else begin
			rd_pend_q <= acc && (s_tuser == OP_READ);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			rd_inside_q <= ld_inside;
		end
	end

	// Output register: load read data or build level, drop on take
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rd_pend_q || eng_done) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_pend_q) begin
			out_cell_q  <= rd_inside_q ? mem_rdata : '0;
			out_level_q <= '0;
		end else if (eng_done) begin
			out_cell_q  <= '0;
			out_level_q <= eng_level;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(TDATA_W-VAL_W-LVL_W){1'b0}}, out_level_q, out_cell_q};

	// No item enters while a build runs
	a_busy_block: assert property (@(posedge clk) disable iff (!arst_n)
		eng_busy |-> !s_tready)
		else $error("item accepted during build");

	// A returning read or finished build always presents a result
	a_result_shown: assert property (@(posedge clk) disable iff (!arst_n)
		(rd_pend_q || eng_done) |=> m_tvalid)
		else $error("result lost");

endmodule

`default_nettype wire

[bench/gcdf_fill_checker.sv]
module gcdf_fill_checker
	import gcdf_pkg::*;
#(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	input  logic                 s_tready,
	input  logic [TDATA_W-1:0]   s_tdata,
	input  logic [OP_W-1:0]      s_tuser,
	input  logic                 m_tvalid,
	input  logic                 m_tready,
	input  logic [TDATA_W-1:0]   m_tdata,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [VAL_W-1:0]     cfg_data,
	output int unsigned          failures,
	output int unsigned          outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [VAL_W-1:0] cell_out;
		logic [LVL_W-1:0] final_level;
	} reply_t;

	logic [VAL_W-1:0] cell_store [MAX_ROWS*MAX_COLS];
	logic [DIM_W-1:0] rows_reg;
	logic [DIM_W-1:0] cols_reg;
	logic [VAL_W-1:0] seed_reg;
	reply_t           awaited_replies [$];
	int unsigned      mismatch_count = 0;
	int unsigned      reply_backlog = 0;

	assign failures    = mismatch_count;
	assign outstanding = reply_backlog;

	task automatic report_mismatch(input string what);
		$display("%0t ns: mismatch: %s", $time, what);
		mismatch_count++;
	endtask

	// One raster sweep: cells equal to match write level into empty neighbors.
	function automatic int unsigned fill_pass(input int unsigned match,
			input int unsigned level, input int nr, input int nc);
		int unsigned filled;
		int r, c, dr, dc, rr, cc;
		filled = 0;
		for (r = 0; r < nr; r++) begin
			for (c = 0; c < nc; c++) begin
				if ({16'd0, cell_store[r*MAX_COLS+c]} != match)
					continue;
				for (dr = -1; dr <= 1; dr++) begin
					for (dc = -1; dc <= 1; dc++) begin
						rr = r + dr;
						cc = c + dc;
						if (rr < 0 || rr >= nr || cc < 0 || cc >= nc)
							continue;
						if (cell_store[rr*MAX_COLS+cc] == '0) begin
							cell_store[rr*MAX_COLS+cc] = VAL_W'(level);
							filled++;
						end
					end
				end
			end
		end
		return filled;
	endfunction

	// Run sweeps until one fills nothing; return the level of that sweep.
	function automatic logic [LVL_W-1:0] spread_wavefront();
		int nr, nc;
		int unsigned match, level;
		nr = (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
		nc = (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
		match = seed_reg;
		level = 1;
		while (fill_pass(match, level, nr, nc) != 0) begin
			match = level;
			level++;
		end
		return LVL_W'(level);
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		reply_t expected, got;
		int addr;
		if (!arst_n) begin
			awaited_replies.delete();
			rows_reg = 7'd64;
			cols_reg = 7'd64;
			seed_reg = 16'd2;
		end else begin
			// compare each result item with the oldest expectation
			if (m_tvalid && m_tready) begin
				got.cell_out    = m_tdata[VAL_W-1:0];
				got.final_level = m_tdata[16 +: LVL_W];
				if (awaited_replies.size() == 0) begin
					report_mismatch($sformatf("result item with nothing pending, tdata %h",
						m_tdata));
				end else begin
					expected = awaited_replies.pop_front();
					if (got.cell_out !== expected.cell_out)
						report_mismatch($sformatf("cell_out %h, expected %h",
							got.cell_out, expected.cell_out));
					if (got.final_level !== expected.final_level)
						report_mismatch($sformatf("final_level %0d, expected %0d",
							got.final_level, expected.final_level));
				end
			end
			// track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_ROWS: rows_reg = cfg_data[DIM_W-1:0];
					REG_COLS: cols_reg = cfg_data[DIM_W-1:0];
					REG_SEED: seed_reg = cfg_data;
					default: ;
				endcase
			end
			// predict each accepted input item
			if (s_tvalid && s_tready) begin
				addr = int'(s_tdata[5:0]) * MAX_COLS + int'(s_tdata[11:6]);
				case (s_tuser)
					OP_WRITE: cell_store[addr] = s_tdata[27:12];
					OP_READ: awaited_replies.push_back('{cell_out: cell_store[addr],
						final_level: '0});
					OP_BUILD: awaited_replies.push_back('{cell_out: '0,
						final_level: spread_wavefront()});
					default: ;
				endcase
			end
		end
		reply_backlog = awaited_replies.size();
	end

endmodule

[bench/grid_chessboard_distance_fill_unit_tb.sv]
module grid_chessboard_distance_fill_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import gcdf_pkg::*;

	localparam int MAX_ROWS      = 64;
	localparam int MAX_COLS      = 64;
	localparam int RANDOM_ITEMS  = 1650;
	localparam int SETTLE_CYCLES = 8;
	localparam int HOLD_CYCLES   = 300;

	// codes the package leaves out: the spare operation and register index
	localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONE  = 2'd3;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata = '0;
	logic [OP_W-1:0]      s_tuser = OP_WRITE;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ROWS;
	logic [VAL_W-1:0]     cfg_data = '0;
	int unsigned          failures;
	int unsigned          outstanding;

	int unsigned send_idle_pct = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned hold_serial = 0;
	int unsigned items_sent = 0;
	int          rows_now = 64;
	int          cols_now = 64;
	logic [VAL_W-1:0] seed_now = 16'd2;
	bit          cell_written [MAX_ROWS*MAX_COLS];
	int          written_cells [$];

	grid_chessboard_distance_fill_unit #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	gcdf_fill_checker #(
		.MAX_ROWS(MAX_ROWS),
		.MAX_COLS(MAX_COLS)
	) fill_check (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.failures(failures),
		.outstanding(outstanding)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Offer one item, with a random gap ahead of it; return once accepted.
	task automatic send_item(input logic [OP_W-1:0] op, input logic [ROW_W-1:0] row,
			input logic [COL_W-1:0] col, input logic [VAL_W-1:0] value);
		int addr;
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {4'd0, value, col, row};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		addr = int'(row) * MAX_COLS + int'(col);
		if (op == OP_WRITE && !cell_written[addr]) begin
			cell_written[addr] = 1'b1;
			written_cells.push_back(addr);
		end
		if (op != OP_UNUSED)
			items_sent++;
	endtask

	// Drop valid, wait for every result, then let a write or spare item finish.
	task automatic wait_idle();
		s_tvalid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] value);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_ROWS: rows_now = int'(value[DIM_W-1:0]);
			REG_COLS: cols_now = int'(value[DIM_W-1:0]);
			REG_SEED: seed_now = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic read_any_written();
		int addr;
		addr = written_cells[$urandom_range(written_cells.size() - 1)];
		send_item(OP_READ, ROW_W'(addr / MAX_COLS), COL_W'(addr % MAX_COLS), VAL_W'($urandom));
	endtask

	// Result side: random stalls, plus a long hold-off when asked for one.
	initial begin : result_sink
		int unsigned hold_left, seen_hold;
		hold_left = 0;
		seen_hold = 0;
		forever begin
			@(posedge clk);
			if (hold_serial != seen_hold) begin
				seen_hold = hold_serial;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				m_tready <= 1'b0;
				hold_left--;
			end else begin
				m_tready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	initial begin : stimulus
		int phase, r, c, pick, rows_sel, cols_sel, area_r, area_c, rewrite_pct;
		int unsigned phase_end;
		logic [VAL_W-1:0] seed_sel, v;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// corner addresses, extreme values, the spare operation and register index
		write_reg(REG_NONE, 16'hFFFF);
		send_item(OP_WRITE, 6'd63, 6'd63, 16'hFFFF);
		send_item(OP_WRITE, 6'd0, 6'd63, 16'h0000);
		send_item(OP_UNUSED, 6'd63, 6'd63, 16'hFFFF);
		send_item(OP_READ, 6'd63, 6'd63, 16'h0000);
		send_item(OP_READ, 6'd0, 6'd63, 16'hFFFF);

		// empty area: nothing filled, level one
		write_reg(REG_ROWS, 16'd0);
		send_item(OP_BUILD, 6'd0, 6'd0, 16'd0);

		// seed one: fresh ones spread within the first sweep
		write_reg(REG_ROWS, 16'd2);
		write_reg(REG_COLS, 16'd3);
		write_reg(REG_SEED, 16'd1);
		for (r = 0; r < 2; r++) begin
			for (c = 0; c < 3; c++)
				send_item(OP_WRITE, ROW_W'(r), COL_W'(c), (r == 0 && c == 0) ? 16'd1 : 16'd0);
		end
		send_item(OP_BUILD, 6'd63, 6'd63, 16'hFFFF);
		send_item(OP_READ, 6'd1, 6'd2, 16'd0);

		// seed zero: every empty cell is a source, obstacle left alone
		write_reg(REG_ROWS, 16'd1);
		write_reg(REG_COLS, 16'd3);
		write_reg(REG_SEED, 16'd0);
		send_item(OP_WRITE, 6'd0, 6'd0, 16'h0000);
		send_item(OP_WRITE, 6'd0, 6'd1, 16'hFFFF);
		send_item(OP_WRITE, 6'd0, 6'd2, 16'h0000);
		send_item(OP_BUILD, 6'd0, 6'd0, 16'd0);
		send_item(OP_READ, 6'd0, 6'd2, 16'd0);

		// random scenes under four idling patterns
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 0;
					sink_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 84;
					sink_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					sink_stall_pct = 84;
				end
				default: begin
					send_idle_pct = 21;
					sink_stall_pct = 21;
				end
			endcase

			// hold off the result side while reads keep coming, so the input backs up
			if (phase == 0) begin
				hold_serial++;
				repeat (24) read_any_written();
			end

			phase_end = items_sent + RANDOM_ITEMS / 4;
			while (items_sent < phase_end) begin
				// pick the area: mostly small, a few tall, wide or empty ones
				pick = $urandom_range(99);
				if (pick < 3) begin
					rows_sel = $urandom_range(64, 127);
					cols_sel = $urandom_range(1, 2);
				end else if (pick < 6) begin
					rows_sel = $urandom_range(1, 2);
					cols_sel = $urandom_range(64, 127);
				end else if (pick < 10) begin
					if ($urandom_range(1)) begin
						rows_sel = 0;
						cols_sel = $urandom_range(1, 8);
					end else begin
						rows_sel = $urandom_range(1, 8);
						cols_sel = 0;
					end
				end else begin
					rows_sel = $urandom_range(1, 8);
					cols_sel = $urandom_range(1, 8);
				end
				pick = $urandom_range(99);
				if (pick < 40)
					seed_sel = VAL_W'($urandom_range(1, 3));
				else if (pick < 50)
					seed_sel = '0;
				else if (pick < 60)
					seed_sel = 16'hFFFF;
				else
					seed_sel = VAL_W'($urandom_range(1, 16'hFFFF));

				// rewrite registers on change, sometimes anyway; upper bits are junk
				if (rows_sel != rows_now || $urandom_range(99) < 40)
					write_reg(REG_ROWS, (VAL_W'($urandom_range(511)) << DIM_W) | VAL_W'(rows_sel));
				if (cols_sel != cols_now || $urandom_range(99) < 40)
					write_reg(REG_COLS, (VAL_W'($urandom_range(511)) << DIM_W) | VAL_W'(cols_sel));
				if (seed_sel != seed_now || $urandom_range(99) < 40)
					write_reg(REG_SEED, seed_sel);

				// load the area: every cell once, then only some on later scenes
				area_r = (rows_now > MAX_ROWS) ? MAX_ROWS : rows_now;
				area_c = (cols_now > MAX_COLS) ? MAX_COLS : cols_now;
				rewrite_pct = (area_r * area_c > 32) ? 15 : 70;
				for (r = 0; r < area_r; r++) begin
					for (c = 0; c < area_c; c++) begin
						if (!cell_written[r*MAX_COLS+c] || $urandom_range(99) < rewrite_pct) begin
							pick = $urandom_range(99);
							if (pick < 62)
								v = '0;
							else if (pick < 74)
								v = seed_now;
							else if (pick < 80)
								v = VAL_W'($urandom_range(1, 4));
							else
								v = VAL_W'($urandom);
							send_item(OP_WRITE, ROW_W'(r), COL_W'(c), v);
						end
					end
				end

				// build, now and then twice over
				send_item(OP_BUILD, ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
				if ($urandom_range(99) < 15)
					send_item(OP_BUILD, ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom));

				// read back filled cells
				repeat ($urandom_range(1, 5)) begin
					if (area_r == 0 || area_c == 0)
						read_any_written();
					else
						send_item(OP_READ, ROW_W'($urandom_range(area_r - 1)),
							COL_W'($urandom_range(area_c - 1)), VAL_W'($urandom));
				end

				// noise: stray writes, stray reads, spare operations
				repeat ($urandom_range(0, 3)) begin
					pick = $urandom_range(2);
					if (pick == 0)
						send_item(OP_WRITE, ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
					else if (pick == 1)
						read_any_written();
					else
						send_item(OP_UNUSED, ROW_W'($urandom), COL_W'($urandom), VAL_W'($urandom));
				end
			end
		end

		wait_idle();
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

	initial begin : watchdog
		#40_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
